### src/sss_pkg.sv
// Package for the sorted store: sizes, function codes and shared types.
// No dependencies.
`default_nettype none
package sss_pkg;
  localparam int Depth      = 32;
  localparam int MaxResults = 32;
  localparam int AddrW      = $clog2(Depth);
  localparam int CntW       = $clog2(Depth + 1);
  localparam int SumW       = 32 + CntW;
  localparam int OutCntW    = 6;

  typedef enum logic [1:0] {
    FuncInsert = 2'd0,
    FuncDump   = 2'd1,
    FuncClear  = 2'd2,
    FuncStatus = 2'd3
  } func_e;

  // divider request and response
  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

### src/sss_if.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on sss_pkg.
`default_nettype none
interface sss_in_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             func;
  logic signed [31:0]     value;
  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface sss_out_if;
  logic                          valid;
  logic                          ready;
  logic [sss_pkg::OutCntW-1:0]   entry_count;
  logic signed [31:0]            min_value;
  logic signed [31:0]            max_value;
  logic signed [31:0]            mean_value;
  logic signed [31:0]            element;
  logic                          last;
  logic                          overflow;
  modport source (output valid, entry_count, min_value, max_value, mean_value,
                  element, last, overflow, input ready);
  modport sink   (input valid, entry_count, min_value, max_value, mean_value,
                  element, last, overflow, output ready);
endinterface
`default_nettype wire

### src/sss_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sss_ram #(
  parameter int Width = 32,
  parameter int Dep   = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [$clog2(Dep)-1:0] waddr_i,
  input  wire logic [Width-1:0]       wdata_i,
  input  wire logic [$clog2(Dep)-1:0] raddr_i,
  output logic      [Width-1:0]       rdata_o
);
  logic [Width-1:0] mem [Dep];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### src/sss_div.sv
// Restoring divider: signed sum by unsigned count, truncated toward zero.
// Depends on sss_pkg.
`default_nettype none
module sss_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sss_pkg::div_req_t req_i,
  output sss_pkg::div_rsp_t      rsp_o
);
  localparam int SumW = sss_pkg::SumW;
  localparam int CntW = sss_pkg::CntW;
  localparam int StepW = $clog2(SumW + 1);

  logic            busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  logic [SumW-1:0] quo_q, quo_d;
  logic [CntW:0]   rem_q, rem_d;
  logic [CntW-1:0] dsr_q, dsr_d;
  logic            neg_q, neg_d;
  logic            done_q, done_d;
  logic [CntW:0]   trial;
  logic [SumW-1:0] quo_s;

  always_comb begin
    busy_d = busy_q; step_d = step_q; quo_d = quo_q; rem_d = rem_q;
    dsr_d = dsr_q; neg_d = neg_q; done_d = 1'b0;
    trial = '0;
    if (req_i.start) begin
      // start with the magnitude of the dividend
      neg_d  = req_i.dividend[SumW-1];
      quo_d  = req_i.dividend[SumW-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
      step_d = StepW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit a cycle
      trial = {rem_q[CntW-1:0], quo_q[SumW-1]};
      quo_d = {quo_q[SumW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; step_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; dsr_q <= dsr_d; neg_q <= neg_d;
  end

  assign quo_s = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_s[31:0];
endmodule
`default_nettype wire

### src/sorted_store_with_stats_core.sv
// Sorted store of Q16.16 values with count, min, max and mean.
// Insert: the shift loop reads and writes the RAM entry by entry, then the
// SumW-bit (38-bit) divider runs one quotient bit a cycle.
// Dump: the same statistics pass, then for each result beat a RAM read, the
// output register and a free slot. Clear, and status or dump on an empty store, skip
// the divider; status on a filled store: the statistics pass. One item at a time. Asynchronous
// active-low reset empties the store; RAM contents need no clearing.
// Depends on sss_pkg, sss_if, sss_ram, sss_div.
`default_nettype none
module sorted_store_with_stats_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sss_in_if.sink     in_i,
  sss_out_if.source  out_o
);
  localparam int AddrW = sss_pkg::AddrW;
  localparam int CntW  = sss_pkg::CntW;
  localparam int SumW  = sss_pkg::SumW;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StScanR = 4'd1;
  localparam logic [3:0] StScanW = 4'd2;
  localparam logic [3:0] StPlace = 4'd3;
  localparam logic [3:0] StDiv   = 4'd4;
  localparam logic [3:0] StMin   = 4'd5;
  localparam logic [3:0] StMax   = 4'd6;
  localparam logic [3:0] StEmit  = 4'd7;
  localparam logic [3:0] StWait  = 4'd8;
  localparam logic [3:0] StDumpR = 4'd9;
  localparam logic [3:0] StDumpW = 4'd10;

  logic [3:0]             st_q, st_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]        pos_q, pos_d;
  logic signed [31:0]     val_q, val_d;
  logic                   isdump_q, isdump_d;
  logic                   ovf_q, ovf_d;
  logic signed [31:0]     min_q, min_d, max_q, max_d, mean_q, mean_d;
  logic                   ovalid_q, ovalid_d;
  logic signed [31:0]     elem_q, elem_d;
  logic                   last_q, last_d;

  logic                we;
  logic [AddrW-1:0]    waddr, raddr;
  logic signed [31:0]  wdata, rdata;
  sss_pkg::div_req_t   dreq;
  sss_pkg::div_rsp_t   drsp;
  logic [CntW-1:0]     dump_n;

  sss_ram #(.Width(32), .Dep(sss_pkg::Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr),
    .rdata_o(rdata)
  );

  sss_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign in_i.ready = (st_q == StIdle) && !ovalid_q;
  assign dump_n = (cnt_q > CntW'(sss_pkg::MaxResults)) ?
                  CntW'(sss_pkg::MaxResults) : cnt_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; sum_d = sum_q; pos_d = pos_q; val_d = val_q;
    isdump_d = isdump_q; ovf_d = ovf_q; min_d = min_q; max_d = max_q;
    mean_d = mean_q; ovalid_d = ovalid_q; elem_d = elem_q; last_d = last_q;
    we = 1'b0; waddr = pos_q[AddrW-1:0]; wdata = val_q;
    raddr = pos_q[AddrW-1:0];
    dreq.start = 1'b0; dreq.dividend = sum_q; dreq.divisor = cnt_q;
    if (ovalid_q && out_o.ready) ovalid_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (in_i.valid && in_i.ready) begin
          val_d = in_i.value; ovf_d = 1'b0; isdump_d = 1'b0;
          pos_d = cnt_q; elem_d = '0; last_d = 1'b1;
          priority case (in_i.func)
            sss_pkg::FuncInsert: begin
              if (cnt_q >= CntW'(sss_pkg::Depth)) begin
                ovf_d = 1'b1; st_d = StDiv;
              end else if (cnt_q == '0) begin
                st_d = StPlace;
              end else begin
                st_d = StScanR;
              end
            end
            sss_pkg::FuncDump: begin
              isdump_d = 1'b1; st_d = StDiv;
            end
            sss_pkg::FuncClear: begin
              cnt_d = '0; sum_d = '0; st_d = StDiv;
            end
            default: st_d = StDiv;
          endcase
        end
      end
      // read entry pos-1
      StScanR: begin
        raddr = AddrW'(pos_q - 1'b1);
        st_d = StScanW;
      end
      // shift it up if greater, else place here
      StScanW: begin
        if (rdata > val_q) begin
          we = 1'b1; waddr = pos_q[AddrW-1:0]; wdata = rdata;
          pos_d = pos_q - 1'b1;
          st_d = (pos_q == CntW'(1)) ? StPlace : StScanR;
        end else begin
          st_d = StPlace;
        end
      end
      StPlace: begin
        we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        sum_d = sum_q + SumW'(val_q);
        st_d = StDiv;
      end
      StDiv: begin
        if (cnt_q == '0) begin
          min_d = '0; max_d = '0; mean_d = '0; st_d = StEmit;
        end else begin
          dreq.start = 1'b1;
          raddr = '0;
          st_d = StMin;
        end
      end
      StMin: begin
        min_d = rdata;
        raddr = AddrW'(cnt_q - 1'b1);
        st_d = StMax;
      end
      StMax: begin
        max_d = rdata;
        st_d = StWait;
      end
      StWait: begin
        if (drsp.done) begin
          mean_d = drsp.quotient;
          pos_d = '0;
          st_d = isdump_q ? StDumpR : StEmit;
        end
      end
      StEmit: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1; st_d = StIdle;
        end
      end
      StDumpR: begin
        if (!ovalid_q) begin
          raddr = pos_q[AddrW-1:0];
          st_d = StDumpW;
        end
      end
      default: begin
        // StDumpW: present one element
        elem_d = rdata;
        last_d = (pos_q + 1'b1) == dump_n;
        ovalid_d = 1'b1;
        pos_d = pos_q + 1'b1;
        st_d = last_d ? StIdle : StDumpR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; sum_q <= '0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; sum_q <= sum_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; val_q <= val_d; isdump_q <= isdump_d; ovf_q <= ovf_d;
    min_q <= min_d; max_q <= max_d; mean_q <= mean_d; elem_q <= elem_d;
    last_q <= last_d;
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.entry_count = sss_pkg::OutCntW'(cnt_q);
  assign out_o.min_value   = min_q;
  assign out_o.max_value   = max_q;
  assign out_o.mean_value  = mean_q;
  assign out_o.element     = elem_q;
  assign out_o.last        = last_q;
  assign out_o.overflow    = ovf_q;
endmodule
`default_nettype wire

### src/sss_checker.sv
// Port-level checks for the sorted store core, bound to the top level.
// Depends on sss_pkg and sss_if.
`default_nettype none
module sss_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready, out_valid, out_ready, out_last, out_ovf,
  input wire logic [sss_pkg::OutCntW-1:0] cnt,
  input wire logic signed [31:0] mn, mx, mean, elem
);
  // one item at a time: no new beat while a result waits
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  // overflow only with a full store and as a final beat
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ovf) |-> (out_last &&
      cnt == sss_pkg::OutCntW'(sss_pkg::Depth))) else $error("bad overflow");
  // statistics are ordered
  a_ord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && cnt != '0) |-> (mn <= mx && mn <= mean && mean <= mx))
    else $error("min/mean/max out of order");
  // empty store reports zeros
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && cnt == '0) |-> (mn == 0 && mx == 0 && mean == 0 && elem == 0))
    else $error("empty store stats nonzero");
  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(elem)))
    else $error("result dropped under stall");
endmodule

bind sorted_store_with_stats_core sss_checker u_chk (
  .clk_i, .rst_ni,
  .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_last(out_o.last), .out_ovf(out_o.overflow), .cnt(out_o.entry_count),
  .mn(out_o.min_value), .mx(out_o.max_value), .mean(out_o.mean_value),
  .elem(out_o.element)
);
`default_nettype wire

### test/sorted_store_with_stats_core_tb.sv
// Testbench for sorted_store_with_stats_core: a directed table, a fill past capacity, then random inserts,
// dumps, clears and status items, all checked beat by beat against a local model.
// Depends on sss_pkg, sss_if and the core RTL.
`default_nettype none
module sorted_store_with_stats_core_tb;

  typedef struct packed {
    logic [5:0]  entry_count;
    logic [31:0] min_value;
    logic [31:0] max_value;
    logic [31:0] mean_value;
    logic [31:0] element;
    logic        last;
    logic        overflow;
  } beat_t;

  typedef struct {
    sss_pkg::func_e func;
    logic [31:0]    value;
    logic           typed;   // expected single beat typed in below
    beat_t          beat;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sss_in_if  in_i ();
  sss_out_if out_o ();

  sorted_store_with_stats_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i.sink),
    .out_o  (out_o.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state
  logic signed [31:0] store_vals[$];
  logic signed [36:0] store_sum;
  beat_t              expected_beats[$];
  int                 errors;
  int                 beats_seen;
  int                 items_sent;
  int                 dumps_sent;
  int                 overflows_seen;
  int                 idle_pct_in;
  int                 idle_pct_out;

  function automatic beat_t stats_beat(logic [31:0] elem, logic lst, logic ovf);
    beat_t b;
    logic signed [36:0] q;
    b.entry_count = 6'(store_vals.size());
    b.min_value   = '0;
    b.max_value   = '0;
    b.mean_value  = '0;
    if (store_vals.size() > 0) begin
      q = store_sum / 37'(signed'(store_vals.size()));
      b.min_value  = store_vals[0];
      b.max_value  = store_vals[store_vals.size()-1];
      b.mean_value = q[31:0];
    end
    b.element  = elem;
    b.last     = lst;
    b.overflow = ovf;
    return b;
  endfunction

  // Applies one accepted item to the local store and queues its beats
  task automatic predict_store(sss_pkg::func_e f, logic signed [31:0] v);
    int pos;
    int n;
    case (f)
      sss_pkg::FuncInsert: begin
        if (store_vals.size() >= sss_pkg::Depth) begin
          expected_beats.push_back(stats_beat('0, 1'b1, 1'b1));
        end else begin
          pos = store_vals.size();
          while (pos > 0 && store_vals[pos-1] > v) pos--;
          store_vals.insert(pos, v);
          store_sum += 37'(v);
          expected_beats.push_back(stats_beat('0, 1'b1, 1'b0));
        end
      end
      sss_pkg::FuncDump: begin
        n = store_vals.size();
        if (n == 0) begin
          expected_beats.push_back(stats_beat('0, 1'b1, 1'b0));
        end else begin
          if (n > sss_pkg::MaxResults) n = sss_pkg::MaxResults;
          for (int i = 0; i < n; i++)
            expected_beats.push_back(stats_beat(store_vals[i], i == n - 1, 1'b0));
        end
      end
      sss_pkg::FuncClear: begin
        store_vals.delete();
        store_sum = '0;
        expected_beats.push_back(stats_beat('0, 1'b1, 1'b0));
      end
      default: expected_beats.push_back(stats_beat('0, 1'b1, 1'b0));
    endcase
  endtask

  // Sends one beat, idling at random first; valid stays up after the beat
  task automatic send_item(sss_pkg::func_e f, logic [31:0] v);
    while ($urandom_range(99) < idle_pct_in) begin
      in_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_i.valid <= 1'b1;
    in_i.func  <= f;
    in_i.value <= v;
    @(posedge clk_i);
    while (!in_i.ready) @(posedge clk_i);
    predict_store(f, v);
    items_sent++;
    if (f == sss_pkg::FuncDump) dumps_sent++;
  endtask

  task automatic wait_drained();
    in_i.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  // Result sink with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
    end else begin
      out_o.ready <= ($urandom_range(99) >= idle_pct_out);
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin
    beat_t got;
    beat_t exp_b;
    if (rst_ni && out_o.valid && out_o.ready) begin
      got = '{out_o.entry_count, out_o.min_value, out_o.max_value, out_o.mean_value,
              out_o.element, out_o.last, out_o.overflow};
      beats_seen++;
      if (got.overflow) overflows_seen++;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %p", $time, got);
      end else begin
        exp_b = expected_beats.pop_front();
        if (got.entry_count !== exp_b.entry_count)
          $display("%0t: entry_count exp %0d got %0d", $time, exp_b.entry_count,
                   got.entry_count);
        if (got.min_value !== exp_b.min_value)
          $display("%0t: min_value exp %h got %h", $time, exp_b.min_value, got.min_value);
        if (got.max_value !== exp_b.max_value)
          $display("%0t: max_value exp %h got %h", $time, exp_b.max_value, got.max_value);
        if (got.mean_value !== exp_b.mean_value)
          $display("%0t: mean_value exp %h got %h", $time, exp_b.mean_value,
                   got.mean_value);
        if (got.element !== exp_b.element)
          $display("%0t: element exp %h got %h", $time, exp_b.element, got.element);
        if (got.last !== exp_b.last)
          $display("%0t: last exp %b got %b", $time, exp_b.last, got.last);
        if (got.overflow !== exp_b.overflow)
          $display("%0t: overflow exp %b got %b", $time, exp_b.overflow, got.overflow);
        if (got !== exp_b) errors++;
      end
    end
  end

  // Directed table; typed rows also check the predictor's newest beat
  row_t dir_rows[$];

  function automatic beat_t mk(int cnt, logic [31:0] mn, logic [31:0] mx,
                               logic [31:0] mean, logic ovf);
    beat_t b;
    b = '{6'(cnt), mn, mx, mean, 32'h0, 1'b1, ovf};
    return b;
  endfunction

  initial begin
    beat_t nul;
    nul = '0;
    dir_rows = '{
      '{sss_pkg::FuncStatus, 32'h0,         1'b1, mk(0, 0, 0, 0, 0)},
      '{sss_pkg::FuncDump,   32'hFFFF_FFFF, 1'b1, mk(0, 0, 0, 0, 0)},
      '{sss_pkg::FuncClear,  32'h1234_5678, 1'b1, mk(0, 0, 0, 0, 0)},
      '{sss_pkg::FuncInsert, 32'h7FFF_FFFF, 1'b1, mk(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                                     32'h7FFF_FFFF, 0)},
      '{sss_pkg::FuncInsert, 32'h7FFF_FFFF, 1'b1, mk(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                                     32'h7FFF_FFFF, 0)},
      '{sss_pkg::FuncInsert, 32'h8000_0000, 1'b0, nul},
      '{sss_pkg::FuncInsert, 32'h0000_0000, 1'b0, nul},
      '{sss_pkg::FuncInsert, 32'hFFFF_FFFF, 1'b0, nul},
      '{sss_pkg::FuncInsert, 32'h0001_0000, 1'b0, nul},
      '{sss_pkg::FuncDump,   32'h0,         1'b0, nul},
      '{sss_pkg::FuncStatus, 32'h0,         1'b0, nul},
      '{sss_pkg::FuncClear,  32'h0,         1'b1, mk(0, 0, 0, 0, 0)},
      '{sss_pkg::FuncInsert, 32'h8000_0000, 1'b1, mk(1, 32'h8000_0000, 32'h8000_0000,
                                                     32'h8000_0000, 0)},
      '{sss_pkg::FuncInsert, 32'h8000_0000, 1'b1, mk(2, 32'h8000_0000, 32'h8000_0000,
                                                     32'h8000_0000, 0)},
      '{sss_pkg::FuncInsert, 32'hFFFF_FFFF, 1'b0, nul},
      '{sss_pkg::FuncDump,   32'h0,         1'b0, nul},
      '{sss_pkg::FuncClear,  32'h0,         1'b1, mk(0, 0, 0, 0, 0)}
    };
  end

  initial begin
    sss_pkg::func_e f;
    logic [31:0] v;
    int r;
    int random_items;
    errors = 0;
    beats_seen = 0;
    items_sent = 0;
    dumps_sent = 0;
    overflows_seen = 0;
    store_sum = '0;
    idle_pct_in = 23;
    idle_pct_out = 23;
    in_i.valid <= 1'b0;
    in_i.func  <= sss_pkg::FuncStatus;
    in_i.value <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].func, dir_rows[k].value);
      if (dir_rows[k].typed && expected_beats[$] !== dir_rows[k].beat) begin
        errors++;
        $display("%0t: table row %0d exp %p predicted %p", $time, k, dir_rows[k].beat,
                 expected_beats[$]);
      end
    end

    // Fill past capacity (the last two inserts overflow), then dump the full store
    for (int i = 0; i < sss_pkg::Depth + 2; i++)
      send_item(sss_pkg::FuncInsert, $urandom());
    send_item(sss_pkg::FuncDump, $urandom());
    // Sender waits for the block to drain completely
    wait_drained();
    send_item(sss_pkg::FuncClear, '0);

    // Random phase, mostly inserts with some dumps, clears and status
    random_items = 56;
    for (int i = 0; i < random_items; i++) begin
      // middle stretch with no idling on either side
      if (i == 15) begin idle_pct_in = 0; idle_pct_out = 0; end
      if (i == 40) begin idle_pct_in = 23; idle_pct_out = 23; end
      r = $urandom_range(99);
      if (r < 70) f = sss_pkg::FuncInsert;
      else if (r < 84) f = sss_pkg::FuncDump;
      else if (r < 92) f = sss_pkg::FuncClear;
      else f = sss_pkg::FuncStatus;
      case ($urandom_range(3))
        0: v = $urandom_range(32'h0002_0000) - 32'h0001_0000;
        1: v = {$urandom_range(1) ? 2'b11 : 2'b00, 30'($urandom())};
        default: v = $urandom();
      endcase
      send_item(f, v);
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d items (%0d dumps), checked %0d result beats, %0d overflows.",
             items_sent, dumps_sent, beats_seen, overflows_seen);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
